// ===== rtl/core/sss_pkg.sv =====
// shared constants and types for the substring search unit
package sss_pkg;

	// default sizes
	localparam int MAX_NEEDLE_DEF   = 16;
	localparam int OFFSET_WIDTH_DEF = 16;

	// register file geometry
	localparam int LEN_W    = 5;
	localparam int NEEDLE_W = 128;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = 2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_NEEDLE_LOW    = 2'd1;
	localparam logic [IDX_W-1:0] REG_NEEDLE_HIGH   = 2'd2;

	// configuration seen by the matcher
	typedef struct packed {
		logic [LEN_W-1:0]    needle_length;
		logic [NEEDLE_W-1:0] needle;
	} cfg_t;

endpackage

// ===== rtl/core/sss_if.sv =====
// valid/ready channels for haystack beats and search results
interface sss_in_if import sss_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] hay_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, hay_byte, first_byte, last_byte, input ready);
	modport sink   (input valid, hay_byte, first_byte, last_byte, output ready);
endinterface

interface sss_out_if import sss_pkg::*; #(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) ();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic [OFFSET_WIDTH-1:0] match_offset;

	modport source (output valid, found, match_offset, input ready);
	modport sink   (input valid, found, match_offset, output ready);
endinterface

// ===== rtl/core/substring_search_unit.sv =====
// Streaming first-match substring search over a haystack byte stream.
// A byte accepted is held in the input register and its result is registered in the result register.
// Throughput: one haystack byte per cycle unless a result waits unaccepted; the compare of all
// needle lengths against the shifted window is combinational between two registers.
// Reset (arst_n low, asynchronous): needle length and bytes cleared, no
// haystack in progress, both channels empty.
module substring_search_unit import sss_pkg::*; #(
	parameter int MAX_NEEDLE   = MAX_NEEDLE_DEF,
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	sss_in_if.sink            hay,
	sss_out_if.source         result
);

	cfg_t cfg;

	// configuration registers
	sss_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// window compare and result register
	sss_matcher #(
		.MAX_NEEDLE   (MAX_NEEDLE),
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_matcher (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.hay    (hay),
		.result (result)
	);

endmodule

// ===== rtl/core/sss_apb_regs.sv =====
// apb register file holding the needle and its length
module sss_apb_regs import sss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [LEN_W-1:0]  len_q;
	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] high_q;
	logic [IDX_W-1:0]  idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			low_q  <= '0;
			high_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_NEEDLE_LENGTH: len_q  <= pwdata[LEN_W-1:0];
				REG_NEEDLE_LOW:    low_q  <= pwdata;
				REG_NEEDLE_HIGH:   high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_NEEDLE_LENGTH: prdata = DATA_W'(len_q);
			REG_NEEDLE_LOW:    prdata = low_q;
			REG_NEEDLE_HIGH:   prdata = high_q;
			default:           prdata = '0;
		endcase
	end

	assign cfg.needle_length = len_q;
	assign cfg.needle        = {high_q, low_q};

endmodule

// ===== rtl/core/sss_matcher.sv =====
// byte window, match compare and result register
module sss_matcher import sss_pkg::*; #(
	parameter int MAX_NEEDLE   = MAX_NEEDLE_DEF,
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	sss_in_if.sink     hay,
	sss_out_if.source  result
);

	localparam int LIDX_W = $clog2(MAX_NEEDLE + 1);
	localparam int CNT_W  = OFFSET_WIDTH + 1;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// search state
	logic [7:0]       win_q [MAX_NEEDLE];
	logic [CNT_W-1:0] cnt_q;
	logic             rep_q;

	// result register
	logic                    res_valid_q;
	logic                    res_found_q;
	logic [OFFSET_WIDTH-1:0] res_off_q;

	logic [7:0]              win_nxt [MAX_NEEDLE];
	logic [MAX_NEEDLE:0]     hit_len;
	logic [LIDX_W-1:0]       len_c;
	logic [CNT_W-1:0]        cnt_base;
	logic [CNT_W-1:0]        cnt_new;
	logic [CNT_W-1:0]        diff;
	logic [OFFSET_WIDTH-1:0] off_c;
	logic                    rep_base;
	logic                    enough;
	logic                    hit;
	logic                    emit;
	logic                    adv;

	// stage handshake
	assign adv       = valid_s1 && (!res_valid_q || result.ready);
	assign hay.ready = !valid_s1 || adv;

	// needle length clamped to the window depth
	assign len_c = (cfg.needle_length > LEN_W'(MAX_NEEDLE)) ? LIDX_W'(MAX_NEEDLE)
		: cfg.needle_length[LIDX_W-1:0];

	// shifted window with the newest byte at the front
	always_comb begin
		win_nxt[0] = byte_s1;
		for (int j = 1; j < MAX_NEEDLE; j++) begin
			win_nxt[j] = win_q[j-1];
		end
	end

	// one compare result per possible needle length
	always_comb begin
		hit_len = '1;
		for (int l = 1; l <= MAX_NEEDLE; l++) begin
			for (int i = 0; i < l; i++) begin
				if (win_nxt[l-1-i] != cfg.needle[8*i +: 8]) begin
					hit_len[l] = 1'b0;
				end
			end
		end
	end

	// byte count, offset and hit decision
	always_comb begin
		cnt_base = first_s1 ? '0 : cnt_q;
		cnt_new  = (&cnt_base) ? cnt_base : cnt_base + CNT_W'(1);
		rep_base = first_s1 ? 1'b0 : rep_q;
		enough   = cnt_new >= CNT_W'(len_c);
		diff     = cnt_new - CNT_W'(len_c);
		off_c    = diff[OFFSET_WIDTH] ? '1 : diff[OFFSET_WIDTH-1:0];
		hit      = !rep_base && ((len_c == '0) || (enough && hit_len[len_c]));
		emit     = hit || (!rep_base && last_s1);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hay.valid && hay.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hay.valid && hay.ready) begin
			byte_s1  <= hay.hay_byte;
			first_s1 <= hay.first_byte;
			last_s1  <= hay.last_byte;
		end
	end

	// search state update, cleared after the last beat of a haystack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rep_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q <= '0;
				rep_q <= 1'b0;
			end else begin
				cnt_q <= cnt_new;
				rep_q <= rep_base || hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < MAX_NEEDLE; j++) begin
				win_q[j] <= win_nxt[j];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (adv && emit) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			res_found_q <= hit;
			res_off_q   <= (hit && (len_c != '0)) ? off_c : '0;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.found        = res_found_q;
	assign result.match_offset = res_off_q;

	// a miss beat is only produced at the end of a haystack
	a_miss_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit && !hit) |-> last_s1)
		else $error("miss beat without last byte");

	// a match inside a haystack marks it reported
	a_hit_sets_rep: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && hit && !last_s1) |=> rep_q)
		else $error("match not recorded");

	// reported implies at least one byte counted
	a_rep_count: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> (cnt_q != '0))
		else $error("report flag with empty count");

	// a miss carries a zero offset
	a_miss_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |-> (res_off_q == '0))
		else $error("nonzero offset on miss");

endmodule

// ===== tb/tb_substring_search_unit.sv =====
// testbench for the streaming first-match substring search unit
module tb_substring_search_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import sss_pkg::*;

	localparam int MAX_N        = MAX_NEEDLE_DEF;
	localparam int OFFSET_W     = OFFSET_WIDTH_DEF;
	localparam int COUNT_W      = OFFSET_W + 1;
	localparam int CLK_PERIOD   = 12;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 6;
	localparam int LONG_HAY_LEN = 40;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 210;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} search_result_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	sss_in_if                             hay_if ();
	sss_out_if #(.OFFSET_WIDTH(OFFSET_W)) res_if ();

	substring_search_unit #(
		.MAX_NEEDLE  (MAX_N),
		.OFFSET_WIDTH(OFFSET_W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.hay    (hay_if),
		.result (res_if)
	);

	// predictor copy of the configuration and search state
	logic [LEN_W-1:0]   needle_len_cfg;
	logic [63:0]        needle_low_cfg;
	logic [63:0]        needle_high_cfg;
	logic [7:0]         hay_window [MAX_N];
	logic [COUNT_W-1:0] hay_count;
	logic               match_reported;
	search_result_t     pending_results [$];

	int error_count = 0;
	int cycle_count = 0;
	int burst_left  = 0;
	int send_gap_max = 0;
	int stall_level  = 0;
	int hold_len     = 0;
	bit hold_trigger = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void clear_search();
		foreach (hay_window[i]) hay_window[i] = 8'h00;
		hay_count      = '0;
		match_reported = 1'b0;
	endfunction

	// shift one haystack byte in and queue the result it causes, if any
	function automatic void scan_hay_byte(input logic [7:0] b, input logic first, input logic last);
		int                  eff_len;
		logic                hit;
		logic [COUNT_W-1:0]  start;
		logic [NEEDLE_W-1:0] needle;
		search_result_t      res;
		needle = {needle_high_cfg, needle_low_cfg};
		if (first) clear_search();
		for (int i = MAX_N - 1; i > 0; i--) hay_window[i] = hay_window[i-1];
		hay_window[0] = b;
		if (hay_count != '1) hay_count++;
		eff_len = (needle_len_cfg > MAX_N) ? MAX_N : int'(needle_len_cfg);
		if (!match_reported) begin
			// window holds the newest byte at index 0
			hit = (hay_count >= eff_len);
			for (int i = 0; i < eff_len; i++)
				if (hay_window[eff_len-1-i] != needle[8*i +: 8]) hit = 1'b0;
			start = (eff_len == 0) ? '0 : hay_count - COUNT_W'(eff_len);
			if (hit) begin
				match_reported = 1'b1;
				res.found  = 1'b1;
				res.offset = start[OFFSET_W] ? '1 : start[OFFSET_W-1:0];
				pending_results.push_back(res);
			end else if (last) begin
				res.found  = 1'b0;
				res.offset = '0;
				pending_results.push_back(res);
			end
		end
		if (last) clear_search();
	endfunction

	// result checker
	always @(posedge clk) begin : check_results
		search_result_t exp_r;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat found=%0b offset=%0d with nothing pending",
					res_if.found, res_if.match_offset));
			end else begin
				exp_r = pending_results.pop_front();
				if (res_if.found !== exp_r.found)
					report_mismatch($sformatf("found %0b, expected %0b",
						res_if.found, exp_r.found));
				if (res_if.match_offset !== exp_r.offset)
					report_mismatch($sformatf("match_offset %0d, expected %0d",
						res_if.match_offset, exp_r.offset));
			end
		end
	end

	// receiver: random stall pattern plus on-demand long hold-off
	initial begin : receiver
		logic [15:0] stall_pattern;
		int          slot;
		int          hold_left;
		bit          hold_seen;
		res_if.ready  = 1'b0;
		stall_pattern = '0;
		slot          = 0;
		hold_left     = 0;
		hold_seen     = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = hold_len;
			end
			if (slot == 0)
				for (int k = 0; k < 16; k++)
					stall_pattern[k] = ($urandom_range(0, 15) < stall_level);
			if (hold_left > 0) begin
				res_if.ready = 1'b0;
				hold_left--;
			end else begin
				res_if.ready = ~stall_pattern[slot];
			end
			slot = (slot + 1) % 16;
		end
	end

	// register write, setup then access phase
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = ADDR_W'({idx, 3'b000});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_NEEDLE_LENGTH: needle_len_cfg  = value[LEN_W-1:0];
			REG_NEEDLE_LOW:    needle_low_cfg  = value[63:0];
			REG_NEEDLE_HIGH:   needle_high_cfg = value[63:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic write_needle(input logic [LEN_W-1:0] len, input logic [63:0] low,
		input logic [63:0] high);
		write_reg(REG_NEEDLE_LENGTH, DATA_W'(len));
		write_reg(REG_NEEDLE_LOW, low);
		write_reg(REG_NEEDLE_HIGH, high);
	endtask

	// one haystack beat, with burst/gap pacing on the sender side
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
			if (gap > 0) begin
				hay_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		hay_if.valid      = 1'b1;
		hay_if.hay_byte   = b;
		hay_if.first_byte = first;
		hay_if.last_byte  = last;
		do @(posedge clk); while (!hay_if.ready);
		scan_hay_byte(b, first, last);
		@(negedge clk);
	endtask

	// stop sending and let every pending result come out
	task automatic drain_results();
		hay_if.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// random haystack, optionally with the needle planted somewhere in it
	task automatic send_haystack(input int hay_len, input bit plant);
		logic [7:0]          hay_q [$];
		int                  eff_len;
		int                  pos;
		logic [NEEDLE_W-1:0] needle;
		needle  = {needle_high_cfg, needle_low_cfg};
		eff_len = (needle_len_cfg > MAX_N) ? MAX_N : int'(needle_len_cfg);
		// filler biased towards needle bytes for near misses
		for (int i = 0; i < hay_len; i++) begin
			if (eff_len > 0 && $urandom_range(0, 1))
				hay_q.push_back(needle[8*$urandom_range(0, eff_len - 1) +: 8]);
			else
				hay_q.push_back(8'($urandom_range(0, 255)));
		end
		if (plant && eff_len > 0 && eff_len <= hay_len) begin
			pos = $urandom_range(0, hay_len - eff_len);
			for (int j = 0; j < eff_len; j++) hay_q[pos+j] = needle[8*j +: 8];
		end
		for (int i = 0; i < hay_len; i++)
			send_byte(hay_q[i], i == 0, i == hay_len - 1);
	endtask

	// reset config: empty needle hits at offset 0 on the first byte
	task automatic test_empty_needle_default();
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
	endtask

	// match completing on the last byte gives only the found beat
	task automatic test_match_on_last();
		drain_results();
		write_needle(5'd2, 64'hFFFF_FFFF_FFFF_00FF, 64'h0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
	endtask

	// needle longer than haystack, then unmarked bytes after the end
	task automatic test_short_haystack_restart();
		send_byte(8'h12, 1'b1, 1'b1);
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b1);
	endtask

	// first mark in the middle restarts the search
	task automatic test_first_mark_mid_haystack();
		send_byte(8'hFF, 1'b1, 1'b0);
		send_byte(8'h00, 1'b1, 1'b1);
	endtask

	// over-long length taken as full needle width
	task automatic test_full_needle();
		drain_results();
		write_needle(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
		for (int i = 0; i < MAX_N; i++)
			send_byte((i < 8) ? 8'hFF : 8'h00, i == 0, i == MAX_N - 1);
	endtask

	// longer haystack with its only match on the final byte
	task automatic test_long_haystack();
		logic [7:0] b;
		drain_results();
		send_gap_max = 0;
		stall_level  = 0;
		write_needle(5'd1, {32'($urandom), 24'($urandom), 8'hAB}, {$urandom, $urandom});
		for (int i = 0; i < LONG_HAY_LEN; i++) begin
			if (i == LONG_HAY_LEN - 1) begin
				b = 8'hAB;
			end else begin
				do b = 8'($urandom_range(0, 255)); while (b == 8'hAB);
			end
			send_byte(b, i == 0, i == LONG_HAY_LEN - 1);
		end
	endtask

	// long receiver hold-off fills the block, then sender waits for all results
	task automatic test_backpressure();
		drain_results();
		write_reg(REG_NEEDLE_LENGTH, DATA_W'(0));
		send_gap_max = 0;
		stall_level  = 0;
		hold_len     = 300;
		hold_trigger = ~hold_trigger;
		repeat (80) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		drain_results();
	endtask

	// random needles and haystacks with varying idling
	task automatic test_random_search();
		int               beats;
		int               hay_len;
		int               noise_len;
		logic [LEN_W-1:0] len;
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case ($urandom_range(0, 9))
				0:       len = 5'd0;
				1:       len = LEN_W'(MAX_N);
				2:       len = LEN_W'($urandom_range(17, 31));
				3:       len = 5'd1;
				default: len = LEN_W'($urandom_range(2, 6));
			endcase
			write_needle(len, {$urandom, $urandom}, {$urandom, $urandom});
			case (phase % 4)
				0:       send_gap_max = 0;
				1:       send_gap_max = 2;
				2:       send_gap_max = 6;
				default: send_gap_max = 12;
			endcase
			stall_level = (phase == 0) ? 0 : $urandom_range(0, 12);
			beats = 0;
			while (beats < PHASE_BEATS) begin
				if ($urandom_range(0, 99) < 85) begin
					hay_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
						: $urandom_range(4, 40);
					send_haystack(hay_len, 1'($urandom_range(0, 1)));
					beats += hay_len;
				end else begin
					// noise: random marks anywhere
					noise_len = $urandom_range(1, 4);
					for (int i = 0; i < noise_len; i++)
						send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
					beats += noise_len;
				end
			end
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		hay_if.valid      = 1'b0;
		hay_if.hay_byte   = 8'h00;
		hay_if.first_byte = 1'b0;
		hay_if.last_byte  = 1'b0;
		needle_len_cfg    = '0;
		needle_low_cfg    = '0;
		needle_high_cfg   = '0;
		clear_search();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_gap_max = 2;
		stall_level  = 4;
		test_empty_needle_default();
		test_match_on_last();
		test_short_haystack_restart();
		test_first_mark_mid_haystack();
		test_full_needle();
		test_long_haystack();
		test_backpressure();
		test_random_search();

		drain_results();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/sss_pkg.sv
rtl/core/sss_if.sv
rtl/core/sss_apb_regs.sv
rtl/core/sss_matcher.sv
rtl/core/substring_search_unit.sv
tb/tb_substring_search_unit.sv
